// ===== rtl/r2dh_pkg.sv =====
// ----------------------------------------------------------------------------
// r2dh_pkg
// Shared constants, types and helpers of the 2D density histogram.
// ----------------------------------------------------------------------------
package r2dh_pkg;

  localparam int BINS_FIRST  = 256;
  localparam int BINS_SECOND = 256;
  localparam int COUNT_BITS  = 32;

  localparam int ROW_BITS    = $clog2(BINS_FIRST);
  localparam int COL_BITS    = $clog2(BINS_SECOND);
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;

  localparam int COORD_BITS  = 32;
  localparam int DATA_BITS   = 32;
  localparam int IDX_BITS    = 28;
  localparam int PROD_BITS   = 64;
  localparam int WIDE_BITS   = 48;
  localparam int SEL_BITS    = 2;

  localparam logic [SEL_BITS-1:0] AXIS_X    = 2'd0;
  localparam logic [SEL_BITS-1:0] AXIS_Y    = 2'd1;
  localparam logic [SEL_BITS-1:0] AXIS_Z    = 2'd2;
  localparam logic [SEL_BITS-1:0] AXIS_NONE = 2'd3;

  localparam logic ACTION_BIN  = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef enum logic [2:0] {
    REG_AXIS_MAP   = 3'd0,
    REG_LOW_FIRST  = 3'd1,
    REG_UP_FIRST   = 3'd2,
    REG_LOW_SECOND = 3'd3,
    REG_UP_SECOND  = 3'd4,
    REG_LOW_SLAB   = 3'd5,
    REG_UP_SLAB    = 3'd6,
    REG_INV_WIDTH  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [5:0]                   axis_map;
    logic signed [COORD_BITS-1:0] low_first;
    logic signed [COORD_BITS-1:0] up_first;
    logic signed [COORD_BITS-1:0] low_second;
    logic signed [COORD_BITS-1:0] up_second;
    logic signed [COORD_BITS-1:0] low_slab;
    logic signed [COORD_BITS-1:0] up_slab;
    logic [DATA_BITS-1:0]         inv_bin_width;
  } cfg_t;

  typedef struct packed {
    logic                done;
    logic                hit;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } idx_res_t;

  function automatic logic [DATA_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
    logic [WIDE_BITS-1:0] wide;
    wide = WIDE_BITS'(c);
    return (wide > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wide[DATA_BITS-1:0];
  endfunction

endpackage

// ===== rtl/region_2d_density_histogram_top.sv =====
// ----------------------------------------------------------------------------
// region_2d_density_histogram_top
// Two-dimensional density histogram over a slab region with a count RAM.
//
//   Channel  Handshake                 Words
//   in       in_valid / in_stall       action, coord_x/y/z, read_row, read_col
//   out      out_valid / out_stall     binned, bin_count
//   cfg      cfg_write                 cfg_index, cfg_data
//
// A bin word runs through the index unit, whose shared multiplier forms both
// indices in turn, and then a read-modify-write of the count RAM with its
// registered read; a read word skips the index unit. After reset a clearing
// pass writes zero to all STORE_DEPTH entries, one per cycle, while in_stall
// is high. A finished word waits in the output register as the next is taken.
// ----------------------------------------------------------------------------
module region_2d_density_histogram_top
  import r2dh_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [7:0]                   read_row,
  input  logic [7:0]                   read_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         binned,
  output logic [DATA_BITS-1:0]         bin_count,
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [DATA_BITS-1:0]         cfg_data
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_INDEX  = 6'b000100,
    ST_ADDR   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  cfg_t     cfg;
  idx_res_t idx_res;

  logic                         act;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic                         hit;
  logic [ROW_BITS-1:0]          row;
  logic [COL_BITS-1:0]          col;
  logic [ADDR_BITS-1:0]         clear_addr;
  logic                         res_binned;
  logic [DATA_BITS-1:0]         res_count;

  logic [IDX_BITS-1:0]   rd_row_ext, rd_col_ext;
  logic                  accept, load_out;
  logic                  mem_we, mem_re;
  logic [ADDR_BITS-1:0]  mem_waddr, mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata, count_inc;

  r2dh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  r2dh_index u_index (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_INDEX),
    .coord_x (cx),
    .coord_y (cy),
    .coord_z (cz),
    .cfg     (cfg),
    .res     (idx_res)
  );

  r2dh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign load_out   = (state == ST_DONE) && (!out_valid || !out_stall);
  assign rd_row_ext = IDX_BITS'(read_row);
  assign rd_col_ext = IDX_BITS'(read_col);
  assign mem_addr   = {row, col};
  assign mem_re     = (state == ST_ADDR);
  assign count_inc  = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr;
    mem_wdata = count_inc;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (state == ST_UPDATE && act == ACTION_BIN && hit) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_addr == '1) state_next = ST_IDLE;
      ST_IDLE:   begin
        if (accept) begin
          state_next = (action == ACTION_READ) ? ST_ADDR : ST_INDEX;
        end
      end
      ST_INDEX:  if (idx_res.done) state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE:   if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_BITS'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action;
      cx  <= coord_x;
      cy  <= coord_y;
      cz  <= coord_z;
      hit <= (rd_row_ext < IDX_BITS'(BINS_FIRST)) && (rd_col_ext < IDX_BITS'(BINS_SECOND));
      row <= rd_row_ext[ROW_BITS-1:0];
      col <= rd_col_ext[COL_BITS-1:0];
    end
    if (state == ST_INDEX && idx_res.done) begin
      hit <= idx_res.hit;
      row <= idx_res.row;
      col <= idx_res.col;
    end
    if (state == ST_UPDATE) begin
      res_binned <= (act == ACTION_BIN) && hit;
      if (!hit) begin
        res_count <= '0;
      end else if (act == ACTION_READ) begin
        res_count <= clamp_count(mem_rdata);
      end else begin
        res_count <= clamp_count(count_inc);
      end
    end
    if (load_out) begin
      binned    <= res_binned;
      bin_count <= res_count;
    end
  end

endmodule

// ===== rtl/r2dh_ram.sv =====
// ----------------------------------------------------------------------------
// r2dh_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module r2dh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/r2dh_cfg.sv =====
// ----------------------------------------------------------------------------
// r2dh_cfg
// Configuration register bank with reset values.
// ----------------------------------------------------------------------------
module r2dh_cfg
  import r2dh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [DATA_BITS-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_map      <= 6'd36;
      cfg.low_first     <= 32'sd1740636;
      cfg.up_first      <= 32'sd4190110;
      cfg.low_second    <= 32'sd1188037;
      cfg.up_second     <= 32'sd3222274;
      cfg.low_slab      <= 32'sd8137998;
      cfg.up_slab       <= 32'sd12833522;
      cfg.inv_bin_width <= 32'd32768000;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_AXIS_MAP:   cfg.axis_map      <= cfg_data[5:0];
        REG_LOW_FIRST:  cfg.low_first     <= cfg_data;
        REG_UP_FIRST:   cfg.up_first      <= cfg_data;
        REG_LOW_SECOND: cfg.low_second    <= cfg_data;
        REG_UP_SECOND:  cfg.up_second     <= cfg_data;
        REG_LOW_SLAB:   cfg.low_slab      <= cfg_data;
        REG_UP_SLAB:    cfg.up_slab       <= cfg_data;
        REG_INV_WIDTH:  cfg.inv_bin_width <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/r2dh_index.sv =====
// ----------------------------------------------------------------------------
// r2dh_index
// Box test and bin index calculation with one shared 32 x 32 multiplier.
// ----------------------------------------------------------------------------
module r2dh_index
  import r2dh_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  cfg_t                         cfg,
  output idx_res_t                     res
);

  typedef enum logic [3:0] {
    IX_IDLE       = 4'b0001,
    IX_MUL_FIRST  = 4'b0010,
    IX_MUL_SECOND = 4'b0100,
    IX_DONE       = 4'b1000
  } ix_state_t;

  ix_state_t state, state_next;

  logic [SEL_BITS-1:0]         sel_first, sel_second, sel_slab;
  logic signed [COORD_BITS-1:0] p_first, p_second, p_slab;
  logic                         in_first, in_second, in_slab, box_ok;
  logic signed [COORD_BITS:0]   d_first, d_second;
  logic [COORD_BITS-1:0]        diff_first, diff_second;
  logic                         ok;
  logic [DATA_BITS-1:0]         mul_a;
  logic [PROD_BITS-1:0]         product;
  logic [IDX_BITS-1:0]          idx_first, idx_second;

  function automatic logic signed [COORD_BITS-1:0] pick(
    input logic [SEL_BITS-1:0]         sel,
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic signed [COORD_BITS-1:0] z
  );
    logic signed [COORD_BITS-1:0] p;
    case (sel)
      AXIS_X:  p = x;
      AXIS_Y:  p = y;
      default: p = z;
    endcase
    return p;
  endfunction

  always_comb begin
    sel_first  = cfg.axis_map[1:0];
    sel_second = cfg.axis_map[3:2];
    sel_slab   = cfg.axis_map[5:4];
    p_first    = pick(sel_first, coord_x, coord_y, coord_z);
    p_second   = pick(sel_second, coord_x, coord_y, coord_z);
    p_slab     = pick(sel_slab, coord_x, coord_y, coord_z);
    in_first   = (p_first >= cfg.low_first) && (p_first < cfg.up_first);
    in_second  = (p_second >= cfg.low_second) && (p_second < cfg.up_second);
    in_slab    = (p_slab >= cfg.low_slab) && (p_slab < cfg.up_slab);
    box_ok     = in_first && in_second && in_slab && (sel_first != AXIS_NONE)
                 && (sel_second != AXIS_NONE) && (sel_slab != AXIS_NONE);
    d_first    = {p_first[COORD_BITS-1], p_first} - {cfg.low_first[COORD_BITS-1], cfg.low_first};
    d_second   = {p_second[COORD_BITS-1], p_second}
                 - {cfg.low_second[COORD_BITS-1], cfg.low_second};
  end

  assign mul_a   = (state == IX_MUL_FIRST) ? diff_first : diff_second;
  assign product = PROD_BITS'(mul_a) * PROD_BITS'(cfg.inv_bin_width);

  always_comb begin
    state_next = state;
    unique case (state)
      IX_IDLE:       if (start) state_next = IX_MUL_FIRST;
      IX_MUL_FIRST:  state_next = IX_MUL_SECOND;
      IX_MUL_SECOND: state_next = IX_DONE;
      IX_DONE:       state_next = IX_IDLE;
      default:       state_next = IX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == IX_IDLE && start) begin
      diff_first  <= d_first[COORD_BITS-1:0];
      diff_second <= d_second[COORD_BITS-1:0];
      ok          <= box_ok;
    end
    if (state == IX_MUL_FIRST) begin
      idx_first <= product[PROD_BITS-1:PROD_BITS-IDX_BITS];
    end
    if (state == IX_MUL_SECOND) begin
      idx_second <= product[PROD_BITS-1:PROD_BITS-IDX_BITS];
    end
  end

  always_comb begin
    res.done = (state == IX_DONE);
    res.hit  = ok && (idx_first < IDX_BITS'(BINS_FIRST))
               && (idx_second < IDX_BITS'(BINS_SECOND));
    res.row  = idx_first[ROW_BITS-1:0];
    res.col  = idx_second[COL_BITS-1:0];
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the two-dimensional density histogram.
//
// Sample and read words are driven into the block with random gaps, and the
// result channel is stalled at random. Every accepted word is run through a
// local model of the box test, the bin index arithmetic and the count store.
// Each result word is then checked in order against that model. Directed
// words cover the box edges, the axis map, the index overrun and the extreme
// register values. Random phases with fresh settings follow, and the run ends
// with a phase that has no idling on either side.
// ----------------------------------------------------------------------------
module tb
  import r2dh_pkg::*;
();

  typedef struct {
    logic               act;
    logic signed [31:0] x, y, z;
    logic [7:0]         row, col;
  } sample_t;

  typedef struct {
    logic                 binned;
    logic [DATA_BITS-1:0] count;
  } tally_t;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         action;
  logic signed [COORD_BITS-1:0] coord_x, coord_y, coord_z;
  logic [7:0]                   read_row, read_col;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         binned;
  logic [DATA_BITS-1:0]         bin_count;
  logic                         cfg_write;
  logic [2:0]                   cfg_index;
  logic [DATA_BITS-1:0]         cfg_data;

  logic [COUNT_BITS-1:0] hist [STORE_DEPTH];
  cfg_t                  regs;
  tally_t                tally_q [$];
  logic [ADDR_BITS-1:0]  hot_bins [$];
  logic                  idling = 1'b1;
  int unsigned           errors = 0;
  int                    stall_left = 0;

  region_2d_density_histogram_top dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tally_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tally_q.size() == 0) begin
        $error("unexpected result word: binned %0d, bin_count %0d", binned, bin_count);
        errors++;
      end else begin
        want = tally_q.pop_front();
        if (binned !== want.binned) begin
          $error("binned: expected %0d, actual %0d", want.binned, binned);
          errors++;
        end
        if (bin_count !== want.count) begin
          $error("bin_count: expected %0d, actual %0d", want.count, bin_count);
          errors++;
        end
      end
    end
  end

  function automatic logic [5:0] axes(input logic [1:0] a, b, s);
    return {s, b, a};
  endfunction

  function automatic cfg_t make_box(input logic [5:0] map,
                                    input logic signed [31:0] lo1, up1, lo2, up2, lo3, up3,
                                    input logic [31:0] inv);
    cfg_t c;
    c.axis_map      = map;
    c.low_first     = lo1;
    c.up_first      = up1;
    c.low_second    = lo2;
    c.up_second     = up2;
    c.low_slab      = lo3;
    c.up_slab       = up3;
    c.inv_bin_width = inv;
    return c;
  endfunction

  function automatic logic [DATA_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide > 64'hFFFF_FFFF) ? '1 : wide[DATA_BITS-1:0];
  endfunction

  // Bin index along one axis, or -1 when the position lies outside [lo, up).
  function automatic longint slot_of(input logic signed [31:0] p, lo, up);
    logic [63:0] d;
    if (!(lo <= p && p < up)) return -64'sd1;
    d = 64'(longint'(p) - longint'(lo));
    return longint'((d * 64'(regs.inv_bin_width)) >> 36);
  endfunction

  function automatic void account_sample(input sample_t s);
    logic signed [31:0]   pos [3];
    logic [1:0]           sa, sb, ss;
    longint               ia, ib, islab;
    logic [ADDR_BITS-1:0] addr;
    tally_t               t;
    t.binned = 1'b0;
    t.count  = '0;
    sa = regs.axis_map[1:0];
    sb = regs.axis_map[3:2];
    ss = regs.axis_map[5:4];
    pos[0] = s.x;
    pos[1] = s.y;
    pos[2] = s.z;
    if (s.act == ACTION_READ) begin
      if (s.row < BINS_FIRST && s.col < BINS_SECOND) begin
        t.count = clip_count(hist[{ROW_BITS'(s.row), COL_BITS'(s.col)}]);
      end
    end else if (sa != AXIS_NONE && sb != AXIS_NONE && ss != AXIS_NONE) begin
      ia    = slot_of(pos[sa], regs.low_first, regs.up_first);
      ib    = slot_of(pos[sb], regs.low_second, regs.up_second);
      islab = slot_of(pos[ss], regs.low_slab, regs.up_slab);
      if (ia >= 0 && ib >= 0 && islab >= 0 && ia < BINS_FIRST && ib < BINS_SECOND) begin
        addr = {ROW_BITS'(ia), COL_BITS'(ib)};
        if (hist[addr] != '1) hist[addr] = hist[addr] + COUNT_BITS'(1);
        t.binned = 1'b1;
        t.count  = clip_count(hist[addr]);
        hot_bins.push_back(addr);
        if (hot_bins.size() > 64) void'(hot_bins.pop_front());
      end
    end
    tally_q.push_back(t);
  endfunction

  function automatic sample_t bin_at(input logic signed [31:0] x, y, z);
    sample_t s;
    s.act = ACTION_BIN;
    s.x   = x;
    s.y   = y;
    s.z   = z;
    s.row = 8'($urandom);
    s.col = 8'($urandom);
    return s;
  endfunction

  function automatic sample_t read_at(input logic [7:0] row, col);
    sample_t s;
    s.act = ACTION_READ;
    s.x   = $urandom;
    s.y   = $urandom;
    s.z   = $urandom;
    s.row = row;
    s.col = col;
    return s;
  endfunction

  function automatic logic signed [31:0] pick_within(input logic signed [31:0] lo, up);
    longint unsigned span;
    longint unsigned r;
    if (lo >= up) return lo;
    span = longint'(up) - longint'(lo);
    case ($urandom_range(0, 15))
      0: return lo;
      1: return up - 1;
      default: ;
    endcase
    r = {$urandom, $urandom};
    return 32'(longint'(lo) + (r % span));
  endfunction

  function automatic sample_t pick_sample();
    sample_t            s;
    logic signed [31:0] c [3];
    int unsigned        r;
    r = $urandom_range(0, 99);
    c[0] = $urandom;
    c[1] = $urandom;
    c[2] = $urandom;
    s.act = ACTION_BIN;
    s.row = 8'($urandom);
    s.col = 8'($urandom);
    if (r < 70) begin
      if (regs.axis_map[5:4] != AXIS_NONE) begin
        c[regs.axis_map[5:4]] = pick_within(regs.low_slab, regs.up_slab);
      end
      if (regs.axis_map[3:2] != AXIS_NONE) begin
        c[regs.axis_map[3:2]] = pick_within(regs.low_second, regs.up_second);
      end
      if (regs.axis_map[1:0] != AXIS_NONE) begin
        c[regs.axis_map[1:0]] = pick_within(regs.low_first, regs.up_first);
      end
    end else if (r < 85) begin
      s.act = ACTION_READ;
      if (hot_bins.size() != 0 && $urandom_range(0, 1) == 1) begin
        {s.row, s.col} = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
      end
    end else begin
      s.act = 1'($urandom_range(0, 1));
    end
    s.x = c[0];
    s.y = c[1];
    s.z = c[2];
    return s;
  endfunction

  // A box of a few to a few hundred bins, now and then an empty one.
  function automatic void span_axis(input logic [31:0] inv,
                                    output logic signed [31:0] lo, up);
    longint w, n, base;
    w    = longint'((64'd1 << 36) / inv);
    n    = ($urandom_range(0, 1) == 1) ? longint'($urandom_range(1, 12))
                                       : longint'($urandom_range(1, 300));
    base = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
    lo   = 32'(base);
    up   = 32'(base + n * w + $urandom_range(0, 32'(w - 1)));
    if ($urandom_range(0, 15) == 0) up = lo - 32'($urandom_range(0, 1000));
  endfunction

  function automatic cfg_t roll_settings();
    cfg_t       c;
    logic [1:0] a, b, s;
    a = 2'($urandom_range(0, 2));
    b = 2'((a + $urandom_range(1, 2)) % 3);
    s = 2'(3 - a - b);
    case ($urandom_range(0, 9))
      0: b = a;
      1: s = AXIS_NONE;
      2: a = AXIS_NONE;
      default: ;
    endcase
    c.axis_map      = axes(a, b, s);
    c.inv_bin_width = $urandom_range(32'h1_0000, 32'h400_0000);
    span_axis(c.inv_bin_width, c.low_first, c.up_first);
    span_axis(c.inv_bin_width, c.low_second, c.up_second);
    span_axis(c.inv_bin_width, c.low_slab, c.up_slab);
    return c;
  endfunction

  task automatic send_sample(input sample_t s);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= s.act;
    coord_x  <= s.x;
    coord_y  <= s.y;
    coord_z  <= s.z;
    read_row <= s.row;
    read_col <= s.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_sample(s);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tally_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    drain();
    write_reg(REG_AXIS_MAP, {26'($urandom), c.axis_map});
    write_reg(REG_LOW_FIRST, c.low_first);
    write_reg(REG_UP_FIRST, c.up_first);
    write_reg(REG_LOW_SECOND, c.low_second);
    write_reg(REG_UP_SECOND, c.up_second);
    write_reg(REG_LOW_SLAB, c.low_slab);
    write_reg(REG_UP_SLAB, c.up_slab);
    write_reg(REG_INV_WIDTH, c.inv_bin_width);
    cfg_write <= 1'b0;
    regs = c;
  endtask

  task automatic test_reset_settings();
    send_sample(bin_at(regs.low_first, regs.low_second, regs.low_slab));
    send_sample(bin_at(regs.low_first, regs.low_second, regs.low_slab));
    send_sample(bin_at(regs.low_first + 2098, regs.low_second + 5000, regs.low_slab + 1));
    send_sample(bin_at(regs.low_first - 1, regs.low_second, regs.low_slab));
    send_sample(bin_at(regs.up_first, regs.low_second, regs.low_slab));
    send_sample(bin_at(regs.up_first - 1, regs.low_second, regs.low_slab));
    send_sample(bin_at(regs.low_first, regs.low_second, regs.up_slab - 1));
    send_sample(bin_at(regs.low_first, regs.low_second, regs.up_slab));
    send_sample(read_at(8'd0, 8'd0));
    send_sample(read_at(8'd1, 8'd2));
    send_sample(read_at(8'hFF, 8'hFF));
  endtask

  task automatic test_axis_map();
    load_settings(make_box(axes(AXIS_Z, AXIS_X, AXIS_Y), 0, 32'sh10_0000,
                           -32'sh10_0000, 0, 32'sh40_0000, 32'sh80_0000, 32'h10_0000));
    send_sample(bin_at(-32'sh10_0000 + 3 * 32'sh1_0000, 32'sh40_0000, 5 * 32'sh1_0000));
    send_sample(read_at(8'd5, 8'd3));
    load_settings(make_box(axes(AXIS_X, AXIS_Y, AXIS_NONE), 0, 32'sh10_0000,
                           -32'sh10_0000, 0, Q_MIN, Q_MAX, 32'h10_0000));
    send_sample(bin_at(32'sh1_0000, -32'sh1_0000, 0));
    load_settings(make_box(axes(AXIS_NONE, AXIS_Y, AXIS_Z), 0, 32'sh10_0000,
                           -32'sh10_0000, 0, Q_MIN, Q_MAX, 32'h10_0000));
    send_sample(bin_at(32'sh1_0000, -32'sh1_0000, 0));
    load_settings(make_box(axes(AXIS_X, AXIS_X, AXIS_Z), 0, 32'sh10_0000,
                           -32'sh10_0000, 32'sh10_0000, 0, 32'sh10_0000, 32'h10_0000));
    send_sample(bin_at(2 * 32'sh1_0000, $urandom, 0));
  endtask

  task automatic test_extreme_bounds();
    load_settings(make_box(axes(AXIS_X, AXIS_Y, AXIS_Z), Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                           Q_MIN, Q_MAX, 32'd1));
    send_sample(bin_at(Q_MIN, Q_MIN, Q_MIN));
    send_sample(bin_at(Q_MAX - 1, Q_MAX - 1, Q_MAX - 1));
    send_sample(bin_at(Q_MAX, 0, 0));
    load_settings(make_box(axes(AXIS_X, AXIS_Y, AXIS_Z), Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                           Q_MIN, Q_MAX, 32'hFFFF_FFFF));
    send_sample(bin_at(Q_MIN + 16, Q_MIN, Q_MAX - 1));
    send_sample(bin_at(Q_MIN + 17, Q_MIN + 4095, 0));
    send_sample(bin_at(Q_MIN + 4113, Q_MIN, 0));
    send_sample(read_at(8'd1, 8'd255));
    load_settings(make_box(axes(AXIS_X, AXIS_Y, AXIS_Z), 0, 0, 100, -100,
                           Q_MIN, Q_MAX, 32'h10_0000));
    send_sample(bin_at(0, 0, 0));
    send_sample(bin_at(0, -100, 0));
  endtask

  task automatic test_random_traffic();
    repeat (6) begin
      load_settings(roll_settings());
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) idling = ($urandom_range(0, 3) != 0);
        send_sample(pick_sample());
      end
    end
  endtask

  task automatic test_back_to_back();
    idling = 1'b0;
    load_settings(roll_settings());
    repeat (250) send_sample(pick_sample());
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACTION_BIN;
    coord_x   = '0;
    coord_y   = '0;
    coord_z   = '0;
    read_row  = '0;
    read_col  = '0;
    cfg_write = 1'b0;
    cfg_index = REG_AXIS_MAP;
    cfg_data  = '0;
    foreach (hist[i]) hist[i] = '0;
    regs = make_box(axes(AXIS_X, AXIS_Y, AXIS_Z), 1740636, 4190110, 1188037, 3222274,
                    8137998, 12833522, 32768000);
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_axis_map();
    test_extreme_bounds();
    test_random_traffic();
    test_back_to_back();
    drain();
    repeat (32) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/r2dh_pkg.sv
rtl/r2dh_ram.sv
rtl/r2dh_cfg.sv
rtl/r2dh_index.sv
rtl/region_2d_density_histogram_top.sv
tb/sv/tb.sv
